@@ design/iru_pkg.sv @@
// ---------------------------------------------------------------------------
// iru_pkg: shared types and constants
// Span type, buffer ids, pass opcodes and the pass program of the engine.
// ---------------------------------------------------------------------------
package iru_pkg;

  localparam int MAX_OUT = 32;

  typedef struct packed {
    logic [31:0] lo;
    logic [31:0] hi;
  } span_t;

  // input kinds
  localparam logic [1:0] KIND_A  = 2'd0;
  localparam logic [1:0] KIND_B  = 2'd1;
  localparam logic [1:0] KIND_GO = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_OP_MODE = 2'd0;
  localparam logic [1:0] REG_WIN_LO  = 2'd1;
  localparam logic [1:0] REG_WIN_HI  = 2'd2;
  localparam logic [1:0] REG_MIN_LEN = 2'd3;

  // buffer ids
  localparam logic [2:0] BUF_A    = 3'd0;
  localparam logic [2:0] BUF_B    = 3'd1;
  localparam logic [2:0] BUF_S0   = 3'd2;
  localparam logic [2:0] BUF_S1   = 3'd3;
  localparam logic [2:0] BUF_S2   = 3'd4;
  localparam logic [2:0] BUF_S3   = 3'd5;
  localparam logic [2:0] BUF_NONE = 3'd7;

  // pass opcodes
  localparam logic [1:0] OP_COMP  = 2'd0;
  localparam logic [1:0] OP_MERGE = 2'd1;
  localparam logic [1:0] OP_FILT  = 2'd2;
  localparam logic [1:0] OP_EMIT  = 2'd3;

  typedef struct packed {
    logic [1:0] op;
    logic [2:0] sx;
    logic [2:0] sy;
    logic [2:0] dst;
    logic       last;
  } prog_t;

  typedef struct packed {
    logic       start;
    logic [1:0] op;
    logic [2:0] sx;
    logic [2:0] sy;
    logic [2:0] dst;
  } pass_cmd_t;

  typedef struct packed {
    logic done;
    logic xor_mode;
  } dp_status_t;

  function automatic prog_t prog_entry(logic xor_mode, logic [3:0] step);
    prog_t p;
    p = '{op: OP_EMIT, sx: BUF_S0, sy: BUF_NONE, dst: BUF_NONE, last: 1'b1};
    if (!xor_mode) begin
      if (step == 4'd0) p = '{OP_MERGE, BUF_A, BUF_B, BUF_S0, 1'b0};
    end else begin
      unique case (step)
        4'd0: p = '{OP_COMP,  BUF_A,  BUF_NONE, BUF_S0, 1'b0};
        4'd1: p = '{OP_MERGE, BUF_S0, BUF_B,    BUF_S1, 1'b0};
        4'd2: p = '{OP_COMP,  BUF_B,  BUF_NONE, BUF_S0, 1'b0};
        4'd3: p = '{OP_MERGE, BUF_S0, BUF_A,    BUF_S2, 1'b0};
        4'd4: p = '{OP_COMP,  BUF_S1, BUF_NONE, BUF_S0, 1'b0};
        4'd5: p = '{OP_COMP,  BUF_S2, BUF_NONE, BUF_S3, 1'b0};
        4'd6: p = '{OP_MERGE, BUF_S0, BUF_S3,   BUF_S1, 1'b0};
        4'd7: p = '{OP_FILT,  BUF_S1, BUF_NONE, BUF_S0, 1'b0};
        default: ;
      endcase
    end
    return p;
  endfunction

endpackage

@@ design/iru_seg_if.sv @@
// ---------------------------------------------------------------------------
// iru_seg_if: input channel
// Load or go transaction: kind plus one segment.
// ---------------------------------------------------------------------------
interface iru_seg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [31:0] seg_begin;
  logic [31:0] seg_end;

  modport source (output valid, kind, seg_begin, seg_end, input ready);
  modport sink   (input valid, kind, seg_begin, seg_end, output ready);
endinterface

@@ design/iru_res_if.sv @@
// ---------------------------------------------------------------------------
// iru_res_if: result channel
// One result segment per transaction with run flags.
// ---------------------------------------------------------------------------
interface iru_res_if;
  logic        valid;
  logic        ready;
  logic [31:0] out_begin;
  logic [31:0] out_end;
  logic        last;
  logic        is_empty;
  logic        overflow;

  modport source (output valid, out_begin, out_end, last, is_empty, overflow,
                  input ready);
  modport sink   (input valid, out_begin, out_end, last, is_empty, overflow,
                  output ready);
endinterface

@@ design/iru_ctrl.sv @@
// ---------------------------------------------------------------------------
// iru_ctrl: pass sequencer
// Steps through the pass program after a go transaction.
// ---------------------------------------------------------------------------
module iru_ctrl
  import iru_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       go,
  input  dp_status_t status,
  output logic       in_ready,
  output pass_cmd_t  cmd
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_ISSUE = 2'd1;
  localparam logic [1:0] ST_WAIT  = 2'd2;

  logic [1:0] state;
  logic [3:0] step;
  prog_t      p;

  assign p        = prog_entry(status.xor_mode, step);
  assign in_ready = (state == ST_IDLE);

  always_comb begin
    cmd       = '0;
    cmd.start = (state == ST_ISSUE);
    cmd.op    = p.op;
    cmd.sx    = p.sx;
    cmd.sy    = p.sy;
    cmd.dst   = p.dst;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step  <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          step <= '0;
          if (go) state <= ST_ISSUE;
        end
        ST_ISSUE: state <= ST_WAIT;
        ST_WAIT: begin
          if (status.done) begin
            if (p.last) begin
              state <= ST_IDLE;
            end else begin
              step  <= step + 4'd1;
              state <= ST_ISSUE;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

@@ design/iru_datapath.sv @@
// ---------------------------------------------------------------------------
// iru_datapath: list stores, scratch buffers and pass engine
// Streams elements one at a time, each a registered read and then a step,
// through complement, merge, filter and emit passes.
// ---------------------------------------------------------------------------
module iru_datapath
  import iru_pkg::*;
#(
  parameter int LIST_DEPTH = 16,
  parameter int COORD_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        load,
  input  logic [1:0]  kind,
  input  logic [31:0] seg_begin,
  input  logic [31:0] seg_end,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  pass_cmd_t   cmd,
  output dp_status_t  status,
  input  logic        out_ready,
  output logic        out_valid,
  output span_t       out_seg,
  output logic        out_last,
  output logic        out_empty,
  output logic        out_overflow
);

  localparam int SCR_DEPTH = 4 * LIST_DEPTH + 8;
  localparam int SW  = $clog2(SCR_DEPTH);
  localparam int CW  = $clog2(SCR_DEPTH + 1);
  localparam int AW  = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int LCW = $clog2(LIST_DEPTH + 1);
  localparam int SH  = 32 - COORD_BITS;

  function automatic logic [31:0] coord_of(logic [31:0] v);
    return 32'($signed(v << SH) >>> SH);
  endfunction

  // config
  logic        op_mode;
  logic [31:0] win_lo_raw, win_hi_raw;
  logic [30:0] min_len;
  logic [31:0] wlo, whi;

  assign wlo = coord_of(win_lo_raw);
  assign whi = coord_of(win_hi_raw);

  always_ff @(posedge clk) begin
    if (rst) begin
      op_mode    <= 1'b1;
      win_lo_raw <= 32'h0;
      win_hi_raw <= 32'h7FFF_FFFF;
      min_len    <= 31'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_OP_MODE: op_mode    <= cfg_data[0];
        REG_WIN_LO:  win_lo_raw <= cfg_data;
        REG_WIN_HI:  win_hi_raw <= cfg_data;
        REG_MIN_LEN: min_len    <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  // stores
  span_t mem_a [LIST_DEPTH];
  span_t mem_b [LIST_DEPTH];
  span_t scr   [4][SCR_DEPTH];
  span_t rd_a, rd_b;
  span_t rd_s  [4];

  logic [LCW-1:0] cnt_a, cnt_b;
  logic [CW-1:0]  cnt_s [4];
  logic           dropped;

  // pass engine state
  logic          busy, phase, tail;
  logic [1:0]    op;
  logic [2:0]    sx, sy, dst;
  logic [CW-1:0] ix, iy, nw, nx, ny;
  logic [31:0]   prev_hi;
  span_t         last_seg;

  logic          wr_en;
  logic [CW-1:0] wr_addr;
  span_t         wr_data;
  logic [CW-1:0] ix_next, iy_next, nw_next;
  logic          tail_next, done_now, out_load;
  logic [31:0]   prev_next;
  span_t         last_next, s, rdx, rdy;
  logic          take_y, cpy, keep, is_last;
  logic [32:0]   len;
  logic [1:0]    dsti;

  assign dsti = 2'(dst - BUF_S0);

  function automatic logic [CW-1:0] cnt_of(logic [2:0] id, logic [LCW-1:0] ca,
                                           logic [LCW-1:0] cb,
                                           logic [CW-1:0] c0, logic [CW-1:0] c1,
                                           logic [CW-1:0] c2, logic [CW-1:0] c3);
    logic [CW-1:0] r;
    unique case (id)
      BUF_A:   r = CW'(ca);
      BUF_B:   r = CW'(cb);
      BUF_S0:  r = c0;
      BUF_S1:  r = c1;
      BUF_S2:  r = c2;
      BUF_S3:  r = c3;
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic span_t rd_of(logic [2:0] id, span_t a, span_t b, span_t r0,
                                  span_t r1, span_t r2, span_t r3);
    span_t r;
    unique case (id)
      BUF_A:   r = a;
      BUF_B:   r = b;
      BUF_S0:  r = r0;
      BUF_S1:  r = r1;
      BUF_S2:  r = r2;
      BUF_S3:  r = r3;
      default: r = '0;
    endcase
    return r;
  endfunction

  assign rdx = rd_of(sx, rd_a, rd_b, rd_s[0], rd_s[1], rd_s[2], rd_s[3]);
  assign rdy = rd_of(sy, rd_a, rd_b, rd_s[0], rd_s[1], rd_s[2], rd_s[3]);

  // registered reads: the y counter addresses the y source, x all others
  always_ff @(posedge clk) begin
    rd_a <= mem_a[(sy == BUF_A) ? iy[AW-1:0] : ix[AW-1:0]];
    rd_b <= mem_b[(sy == BUF_B) ? iy[AW-1:0] : ix[AW-1:0]];
    for (int k = 0; k < 4; k++) begin
      rd_s[k] <= scr[k][(sy == 3'(k + 2)) ? iy[SW-1:0] : ix[SW-1:0]];
    end
  end

  // one step of the active pass
  always_comb begin
    wr_en     = 1'b0;
    wr_addr   = nw;
    wr_data   = '0;
    nw_next   = nw;
    ix_next   = ix;
    iy_next   = iy;
    tail_next = tail;
    prev_next = prev_hi;
    last_next = last_seg;
    done_now  = 1'b0;
    out_load  = 1'b0;
    cpy       = (nx == '0) || (ny == '0);
    take_y    = (iy < ny) && ((ix >= nx) || (!cpy && $signed(rdy.lo) <= $signed(rdx.lo)));
    s         = take_y ? rdy : rdx;
    len       = {rdx.hi[31], rdx.hi} - {rdx.lo[31], rdx.lo};
    keep      = $signed(len) >= $signed({2'b00, min_len});
    is_last   = (ix + CW'(1) == nx) || (32'(ix) == MAX_OUT - 1);
    if (busy && phase) begin
      unique case (op)
        OP_COMP: begin
          if (nx == '0) begin
            wr_en    = 1'b1;
            wr_addr  = '0;
            wr_data  = '{wlo, whi};
            nw_next  = CW'(1);
            done_now = 1'b1;
          end else if (tail) begin
            if ($signed(prev_hi) < $signed(whi)) begin
              wr_en   = 1'b1;
              wr_data = '{prev_hi, whi};
              nw_next = nw + CW'(1);
            end
            done_now = 1'b1;
          end else begin
            if (ix == '0) begin
              if ($signed(rdx.lo) > $signed(wlo)) begin
                wr_en   = 1'b1;
                wr_data = '{wlo, rdx.lo};
                nw_next = nw + CW'(1);
              end
            end else begin
              wr_en   = 1'b1;
              wr_data = '{prev_hi, rdx.lo};
              nw_next = nw + CW'(1);
            end
            prev_next = rdx.hi;
            ix_next   = ix + CW'(1);
            if (ix + CW'(1) == nx) tail_next = 1'b1;
          end
        end
        OP_MERGE: begin
          if (ix >= nx && iy >= ny) begin
            done_now = 1'b1;
          end else begin
            // copy mode passes a lone list through without joining
            if (cpy || nw == '0 || $signed(last_seg.hi) < $signed(s.lo)) begin
              wr_en     = 1'b1;
              wr_data   = s;
              nw_next   = nw + CW'(1);
              last_next = s;
            end else if ($signed(s.hi) > $signed(last_seg.hi)) begin
              wr_en        = 1'b1;
              wr_addr      = nw - CW'(1);
              wr_data      = '{last_seg.lo, s.hi};
              last_next.hi = s.hi;
            end
            if (take_y) iy_next = iy + CW'(1);
            else        ix_next = ix + CW'(1);
          end
        end
        OP_FILT: begin
          if (ix >= nx) begin
            done_now = 1'b1;
          end else begin
            if (keep) begin
              wr_en   = 1'b1;
              wr_data = rdx;
              nw_next = nw + CW'(1);
            end
            ix_next = ix + CW'(1);
          end
        end
        OP_EMIT: begin
          if (!out_valid) begin
            out_load = 1'b1;
            if (nx == '0) done_now = 1'b1;
            else begin
              ix_next  = ix + CW'(1);
              done_now = is_last;
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign status.done     = done_now;
  assign status.xor_mode = op_mode;

  always_ff @(posedge clk) begin
    if (wr_en) scr[dsti][wr_addr[SW-1:0]] <= wr_data;
    if (load && kind == KIND_A && cnt_a < LCW'(LIST_DEPTH))
      mem_a[cnt_a[AW-1:0]] <= '{coord_of(seg_begin), coord_of(seg_end)};
    if (load && kind == KIND_B && cnt_b < LCW'(LIST_DEPTH))
      mem_b[cnt_b[AW-1:0]] <= '{coord_of(seg_begin), coord_of(seg_end)};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      phase     <= 1'b0;
      cnt_a     <= '0;
      cnt_b     <= '0;
      dropped   <= 1'b0;
      out_valid <= 1'b0;
      for (int k = 0; k < 4; k++) cnt_s[k] <= '0;
    end else begin
      if (load && kind == KIND_A) begin
        if (cnt_a < LCW'(LIST_DEPTH)) cnt_a <= cnt_a + LCW'(1);
        else dropped <= 1'b1;
      end
      if (load && kind == KIND_B) begin
        if (cnt_b < LCW'(LIST_DEPTH)) cnt_b <= cnt_b + LCW'(1);
        else dropped <= 1'b1;
      end
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (out_load) out_valid <= 1'b1;
      if (cmd.start) begin
        busy  <= 1'b1;
        phase <= 1'b0;
      end else if (busy) begin
        phase <= ~phase;
        if (done_now) begin
          busy <= 1'b0;
          if (op == OP_EMIT) begin
            cnt_a   <= '0;
            cnt_b   <= '0;
            dropped <= 1'b0;
          end else begin
            cnt_s[dsti] <= nw_next;
          end
        end
      end
    end
  end

  // pass registers and result payload
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      op   <= cmd.op;
      sx   <= cmd.sx;
      sy   <= cmd.sy;
      dst  <= cmd.dst;
      ix   <= '0;
      iy   <= '0;
      nw   <= '0;
      tail <= 1'b0;
      nx   <= cnt_of(cmd.sx, cnt_a, cnt_b, cnt_s[0], cnt_s[1], cnt_s[2], cnt_s[3]);
      ny   <= cnt_of(cmd.sy, cnt_a, cnt_b, cnt_s[0], cnt_s[1], cnt_s[2], cnt_s[3]);
    end else begin
      ix       <= ix_next;
      iy       <= iy_next;
      nw       <= nw_next;
      tail     <= tail_next;
      prev_hi  <= prev_next;
      last_seg <= last_next;
    end
    if (out_load) begin
      out_overflow <= dropped;
      if (nx == '0) begin
        out_seg   <= '0;
        out_last  <= 1'b1;
        out_empty <= 1'b1;
      end else begin
        out_seg   <= rdx;
        out_last  <= is_last;
        out_empty <= 1'b0;
      end
    end
  end

endmodule

@@ design/interval_run_union_xor_core.sv @@
// ---------------------------------------------------------------------------
// interval_run_union_xor_core: segment list union / symmetric difference
// Load transactions are taken while in_ready is high; it stays high while idle.
// A go runs the pass program: union is a merge and an emit; xor is four
// complements, three merges, a filter and an emit. Each element is a
// registered store read, then a step; a go holds in_ready low until the
// emit pass is done, and the emit pass waits while a result is stalled.
// Reset (synchronous, rst high) clears counts, flags and config to defaults.
// ---------------------------------------------------------------------------
module interval_run_union_xor_core
  import iru_pkg::*;
#(
  parameter int LIST_DEPTH = 16,
  parameter int COORD_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  iru_seg_if.sink     seg_in,
  iru_res_if.source   res_out,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  pass_cmd_t  cmd;
  dp_status_t status;
  logic       in_ready;
  logic       in_fire;
  span_t      out_seg;

  // a transaction lands when the sequencer is idle
  assign seg_in.ready = in_ready;
  assign in_fire      = seg_in.valid && in_ready;

  iru_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .go       (in_fire && seg_in.kind == KIND_GO),
    .status   (status),
    .in_ready (in_ready),
    .cmd      (cmd)
  );

  // stores, scratch buffers and the result register
  iru_datapath #(
    .LIST_DEPTH (LIST_DEPTH),
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .load         (in_fire),
    .kind         (seg_in.kind),
    .seg_begin    (seg_in.seg_begin),
    .seg_end      (seg_in.seg_end),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .cmd          (cmd),
    .status       (status),
    .out_ready    (res_out.ready),
    .out_valid    (res_out.valid),
    .out_seg      (out_seg),
    .out_last     (res_out.last),
    .out_empty    (res_out.is_empty),
    .out_overflow (res_out.overflow)
  );

  assign res_out.out_begin = out_seg.lo;
  assign res_out.out_end   = out_seg.hi;

endmodule

@@ design/iru_checker.sv @@
// ---------------------------------------------------------------------------
// iru_checker: port-level checks
// Watches the channels of the core over time.
// ---------------------------------------------------------------------------
module iru_checker
  import iru_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic [1:0]  in_kind,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_begin,
  input logic [31:0] out_end,
  input logic        out_last,
  input logic        out_empty
);

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_begin) && $stable(out_end)
      && $stable(out_last))
    else $error("result changed while stalled");

  a_empty_item: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_empty |-> out_last && out_begin == 32'd0 && out_end == 32'd0)
    else $error("empty result not a sole zero item");

  a_go_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_kind == KIND_GO |=> !in_ready)
    else $error("input taken right after go");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind interval_run_union_xor_core iru_checker u_chk (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (seg_in.valid),
  .in_ready  (seg_in.ready),
  .in_kind   (seg_in.kind),
  .out_valid (res_out.valid),
  .out_ready (res_out.ready),
  .out_begin (res_out.out_begin),
  .out_end   (res_out.out_end),
  .out_last  (res_out.last),
  .out_empty (res_out.is_empty)
);

@@ tb/interval_run_union_xor_core_tb.sv @@
// ---------------------------------------------------------------------------
// interval_run_union_xor_core_tb: self-checking bench for the segment engine
// Loads segment lists A and B, fires go transactions in union and xor mode
// over several window / min_len settings, and checks every result
// transaction against a behavioral model kept inside the bench.
// ---------------------------------------------------------------------------
module interval_run_union_xor_core_tb;
  import iru_pkg::*;

  localparam int DEPTH      = 16;
  localparam int IDLE_LIMIT = 5000;  // cycles without any transaction
  localparam int HOLD_LEN   = 400;   // long receiver hold-off
  localparam int N_ITEMS    = 160;   // input transactions for the whole run

  typedef struct {
    longint lo;
    longint hi;
  } seg_t;
  typedef seg_t seg_q_t[$];

  typedef struct {
    logic [31:0] b;
    logic [31:0] e;
    logic        last;
    logic        empty;
    logic        ovf;
  } res_t;

  logic clk;
  logic rst;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;

  iru_seg_if seg_in ();
  iru_res_if res_out ();

  interval_run_union_xor_core u_dut (
    .clk      (clk),
    .rst      (rst),
    .seg_in   (seg_in.sink),
    .res_out  (res_out.source),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // model state: the two lists, drop flag and register shadows
  seg_q_t list_a;
  seg_q_t list_b;
  bit     drop_seen;
  bit     xor_mode;
  longint win_lo;
  longint win_hi;
  longint min_len;

  res_t   seg_results_due[$];
  int     errors;
  int     burst_left;
  int     items_sent;
  int     hold_reqs;
  int     hold_seen;
  int     hold_cnt;
  int     idle_cycles;
  int     ready_cycle;

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // ---------------------------------------------------------------------------
  // behavioral model
  // ---------------------------------------------------------------------------
  // merge by begin, joining overlapping or touching neighbors; an empty side
  // passes the other list through untouched (no joining then)
  function automatic seg_q_t merge_segs(seg_q_t a, seg_q_t b);
    seg_q_t r;
    seg_t   s;
    int     ia;
    int     ib;
    ia = 0;
    ib = 0;
    if (a.size() == 0) return b;
    if (b.size() == 0) return a;
    while (ia < a.size() || ib < b.size()) begin
      if (ib < b.size() && (ia >= a.size() || b[ib].lo <= a[ia].lo)) begin
        s = b[ib];
        ib++;
      end else begin
        s = a[ia];
        ia++;
      end
      if (r.size() == 0 || r[r.size()-1].hi < s.lo) r = {r, s};
      else if (s.hi > r[r.size()-1].hi) r[r.size()-1].hi = s.hi;
    end
    return r;
  endfunction

  // gaps of the list inside [lo, hi]
  function automatic seg_q_t invert_segs(seg_q_t in, longint lo, longint hi);
    seg_q_t r;
    int     n;
    n = in.size();
    if (n == 0) begin
      r = {r, seg_t'{lo, hi}};
      return r;
    end
    if (in[0].lo > lo) r = {r, seg_t'{lo, in[0].lo}};
    for (int i = 0; i + 1 < n; i++) r = {r, seg_t'{in[i].hi, in[i+1].lo}};
    if (in[n-1].hi < hi) r = {r, seg_t'{in[n-1].hi, hi}};
    return r;
  endfunction

  // result set of one go; queues the result transactions and clears lists
  task automatic predict_run();
    seg_q_t u1;
    seg_q_t u2;
    seg_q_t d;
    seg_q_t res;
    int     n;
    if (!xor_mode) begin
      res = merge_segs(list_a, list_b);
    end else begin
      u1 = merge_segs(invert_segs(list_a, win_lo, win_hi), list_b);
      u2 = merge_segs(invert_segs(list_b, win_lo, win_hi), list_a);
      d  = merge_segs(invert_segs(u1, win_lo, win_hi), invert_segs(u2, win_lo, win_hi));
      foreach (d[i]) if (d[i].hi - d[i].lo >= min_len) res = {res, d[i]};
    end
    if (res.size() == 0) begin
      seg_results_due = {seg_results_due, res_t'{32'd0, 32'd0, 1'b1, 1'b1, drop_seen}};
    end else begin
      n = (res.size() > MAX_OUT) ? MAX_OUT : res.size();
      for (int i = 0; i < n; i++)
        seg_results_due = {seg_results_due,
                           res_t'{res[i].lo[31:0], res[i].hi[31:0], i == n - 1,
                                  1'b0, drop_seen}};
    end
    list_a.delete();
    list_b.delete();
    drop_seen = 1'b0;
  endtask

  task automatic model_accept(logic [1:0] kind, logic [31:0] b, logic [31:0] e);
    seg_t s;
    s = '{longint'($signed(b)), longint'($signed(e))};
    if (kind == KIND_A) begin
      if (list_a.size() < DEPTH) list_a = {list_a, s};
      else drop_seen = 1'b1;
    end else if (kind == KIND_B) begin
      if (list_b.size() < DEPTH) list_b = {list_b, s};
      else drop_seen = 1'b1;
    end else if (kind == KIND_GO) begin
      predict_run();
    end
  endtask

  // ---------------------------------------------------------------------------
  // driving
  // ---------------------------------------------------------------------------
  // one input transaction; sender runs in bursts with random gaps between
  task automatic send_seg(logic [1:0] kind, logic [31:0] b, logic [31:0] e);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 5);
      if (gap > 0) begin
        seg_in.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 8);
    end
    seg_in.valid     <= 1'b1;
    seg_in.kind      <= kind;
    seg_in.seg_begin <= b;
    seg_in.seg_end   <= e;
    @(posedge clk);
    while (!seg_in.ready) @(posedge clk);
    model_accept(kind, b, e);
    items_sent++;
    burst_left--;
  endtask

  task automatic send_go();
    send_seg(KIND_GO, $urandom, $urandom);
  endtask

  // drain all results and let the engine go quiet before touching registers
  task automatic settle();
    seg_in.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (seg_results_due.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    case (idx)
      REG_OP_MODE: xor_mode = data[0];
      REG_WIN_LO:  win_lo = longint'($signed(data));
      REG_WIN_HI:  win_hi = longint'($signed(data));
      REG_MIN_LEN: min_len = longint'(data[30:0]);
      default: ;
    endcase
  endtask

  task automatic set_config(bit mode, int lo, int hi, int mlen);
    settle();
    write_reg(REG_OP_MODE, {31'd0, mode});
    write_reg(REG_WIN_LO, lo);
    write_reg(REG_WIN_HI, hi);
    write_reg(REG_MIN_LEN, mlen);
    cfg_we <= 1'b0;
  endtask

  // up to n sorted, non-overlapping segments inside [lo, hi]; gap 0 gives touching
  task automatic load_sorted(logic [1:0] kind, int n, longint lo, longint hi);
    longint step;
    longint pos;
    longint b;
    longint e;
    step = (hi - lo) / (4 * n + 1);
    if (step < 1) step = 1;
    pos = lo + $urandom_range(0, 2) * step;
    for (int i = 0; i < n; i++) begin
      b = pos + $urandom_range(0, int'(step));
      e = b + $urandom_range(0, int'(step));
      if (e > hi) break;
      send_seg(kind, b[31:0], e[31:0]);
      pos = e + (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, int'(step)));
    end
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------
  task automatic test_union_directed();
    set_config(1'b0, 0, 1000, 1);
    send_go();                                   // both lists empty
    send_seg(KIND_A, 0, 10);
    send_go();                                   // only A
    send_seg(KIND_A, 0, 10);
    send_seg(KIND_A, 20, 30);
    send_seg(KIND_B, 10, 15);                    // touches A
    send_seg(KIND_B, 25, 40);                    // overlaps A
    send_go();
    send_seg(KIND_B, 32'h8000_0000, 32'h7fff_ffff);  // coordinate extremes
    send_seg(2'd3, 32'hffff_ffff, 32'hffff_ffff);    // unused kind, ignored
    send_go();
  endtask

  task automatic test_xor_directed();
    set_config(1'b1, 0, 100, 1);
    send_seg(KIND_A, 10, 20);
    send_seg(KIND_B, 10, 20);
    send_go();                                   // A equals B: empty
    send_seg(KIND_A, 0, 50);
    send_seg(KIND_B, 30, 100);
    send_go();
    send_go();                                   // xor of nothing
  endtask

  task automatic test_overflow();
    set_config(1'b1, -1000, 1000, 0);
    for (int i = 0; i < DEPTH + 2; i++) send_seg(KIND_A, i * 50 - 900, i * 50 - 880);
    send_seg(KIND_B, -950, 950);
    send_go();
    set_config(1'b0, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff);
    for (int i = 0; i < DEPTH + 1; i++) send_seg(KIND_B, i * 4, i * 4 + 2);
    send_go();
  endtask

  task automatic test_random();
    longint lo;
    longint hi;
    int     sel;
    for (int ph = 0; items_sent < N_ITEMS; ph++) begin
      sel = ph % 4;
      if (sel == 3) begin
        lo = -longint'(32'h7fff_ffff) - 1;
        hi = 2147483647;
      end else begin
        lo = -longint'($urandom_range(0, 100000));
        hi = lo + longint'($urandom_range(10, 200000));
      end
      if (ph % 5 == 4) set_config(ph[0], $urandom, $urandom, $urandom);
      else set_config(1'($urandom_range(0, 1)), int'(lo), int'(hi),
                      (sel == 2) ? $urandom_range(0, 2000) : $urandom_range(0, 2));
      for (int r = 0; r < 4 && items_sent < N_ITEMS; r++) begin
        if ($urandom_range(0, 5) == 0) begin
          // noise: ill-formed lists and unused kinds
          repeat ($urandom_range(1, 6)) begin
            send_seg(2'($urandom_range(0, 3)), $urandom, $urandom);
          end
        end else begin
          load_sorted(KIND_A, $urandom_range(0, 17), lo, hi);
          load_sorted(KIND_B, $urandom_range(0, 17), lo, hi);
        end
        send_go();
      end
    end
  endtask

  // receiver holds off long while loads and gos keep coming
  task automatic test_backpressure();
    set_config(1'b1, 0, 4000, 1);
    hold_reqs++;
    repeat (3) begin
      load_sorted(KIND_A, 6, 0, 4000);
      load_sorted(KIND_B, 6, 0, 4000);
      send_go();
    end
  endtask

  // ---------------------------------------------------------------------------
  // result checking and receiver stall pattern
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    res_t x;
    if (rst) begin
      res_out.ready <= 1'b0;
    end else begin
      if (res_out.valid && res_out.ready) begin
        if (seg_results_due.size() == 0) begin
          $error("result transaction with nothing pending");
          errors++;
        end else begin
          x = seg_results_due.pop_front();
          if (res_out.out_begin !== x.b) begin
            $error("out_begin exp %h got %h", x.b, res_out.out_begin);
            errors++;
          end
          if (res_out.out_end !== x.e) begin
            $error("out_end exp %h got %h", x.e, res_out.out_end);
            errors++;
          end
          if (res_out.last !== x.last) begin
            $error("last exp %b got %b", x.last, res_out.last);
            errors++;
          end
          if (res_out.is_empty !== x.empty) begin
            $error("is_empty exp %b got %b", x.empty, res_out.is_empty);
            errors++;
          end
          if (res_out.overflow !== x.ovf) begin
            $error("overflow exp %b got %b", x.ovf, res_out.overflow);
            errors++;
          end
        end
      end
      if (hold_reqs != hold_seen) begin
        hold_seen = hold_reqs;
        hold_cnt  = HOLD_LEN;
      end
      ready_cycle++;
      if (hold_cnt > 0) begin
        hold_cnt--;
        res_out.ready <= 1'b0;
      end else begin
        // stall pattern steps through four settings in turn
        case ((ready_cycle / 128) % 4)
          0: res_out.ready <= 1'b1;
          1: res_out.ready <= $urandom_range(0, 1);
          2: res_out.ready <= (ready_cycle % 4 == 0);
          default: res_out.ready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  // watchdog: ends the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (seg_in.valid && seg_in.ready) || (res_out.valid && res_out.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst          = 1'b1;
    cfg_we       = 1'b0;
    cfg_index    = REG_OP_MODE;
    cfg_data     = '0;
    seg_in.valid = 1'b0;
    seg_in.kind  = KIND_A;
    seg_in.seg_begin = '0;
    seg_in.seg_end   = '0;
    burst_left  = 0;
    items_sent  = 0;
    hold_reqs   = 0;
    drop_seen   = 1'b0;
    xor_mode    = 1'b1;       // reset defaults of the block
    win_lo      = 0;
    win_hi      = 2147483647;
    min_len     = 1;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_xor_directed();
    test_union_directed();
    test_overflow();
    test_backpressure();
    test_random();

    settle();
    if (errors == 0 && seg_results_due.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
